// ----- hw/rtl/dpws_pkg.sv -----
package dpws_pkg;

	localparam int ADDR_W  = 22;
	localparam int DATA_W  = 8;
	localparam int LEN_W   = 16;
	localparam int PAGE_W  = 13;
	localparam int OFS_W   = 10;
	localparam int PACK_W  = 24;
	localparam int STEP_W  = 4;

	localparam int PAGE_COUNT_DEF = 4096;

	// Both page sizes are 33 times a power of two; x / 33 = (x * RECIP_33) >> DIV_SHIFT,
	// exact for any x below 2^19.
	localparam int              DIV_X_W    = 19;
	localparam int              PROD_W     = 2 * DIV_X_W;
	localparam int              DIV_SHIFT  = 24;
	localparam logic [18:0]     RECIP_33   = 19'd508401;
	localparam int              QUOT_W     = PROD_W - DIV_SHIFT;
	localparam int              QUOT_LIMIT = (1 << DIV_X_W) / 33 + 1;

	localparam logic [10:0] PAGE_SIZE_SMALL = 11'd264;
	localparam logic [10:0] PAGE_SIZE_LARGE = 11'd528;

	localparam logic [7:0] CMD_MEM_TO_BUF = 8'h53;
	localparam logic [7:0] CMD_BUF_WRITE  = 8'h84;
	localparam logic [7:0] CMD_PROGRAM    = 8'h83;
	localparam logic [7:0] CMD_READ       = 8'hE8;

	localparam int JOB_DEPTH = 2;

	typedef enum logic [1:0] {
		ACT_SEND    = 2'd0,
		ACT_DESEL   = 2'd1,
		ACT_POLL    = 2'd2,
		ACT_RECEIVE = 2'd3
	} action_t;

	typedef struct packed {
		logic              is_read;
		logic              open;      // write: open a chunk before the data byte
		logic              close;     // write: close after data; read: close before read
		logic              read_go;
		logic [PACK_W-1:0] close_addr;
		logic [PACK_W-1:0] op_addr;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  rlen;
	} job_t;

	function automatic logic [PACK_W-1:0] pack_addr(input logic [PAGE_W-1:0] page,
			input logic [OFS_W-1:0] ofs, input logic mode);
		logic [PACK_W-1:0] pg_ext;
		pg_ext = PACK_W'(page);
		if (mode) begin
			pack_addr = (pg_ext << 10) + PACK_W'(ofs);
		end else begin
			pack_addr = (pg_ext << 9) + PACK_W'(ofs);
		end
	endfunction

endpackage

// ----- hw/rtl/dpws_front.sv -----
module dpws_front #(
	parameter int PAGE_COUNT = dpws_pkg::PAGE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        page_mode,
	input  logic                        push,
	output logic                        full,
	input  logic                        operation,
	input  logic [dpws_pkg::ADDR_W-1:0] start_address,
	input  logic [dpws_pkg::DATA_W-1:0] data_byte,
	input  logic [dpws_pkg::LEN_W-1:0]  read_length,
	input  logic                        transfer_end,
	output logic                        job_push,
	input  logic                        job_full,
	output dpws_pkg::job_t              job
);

	localparam int MOD_STEPS = $clog2((dpws_pkg::QUOT_LIMIT + PAGE_COUNT - 1) / PAGE_COUNT);

	typedef enum logic [3:0] {
		FS_IDLE  = 4'b0001,
		FS_MUL   = 4'b0010,
		FS_SPLIT = 4'b0100,
		FS_ISSUE = 4'b1000
	} fstate_t;

	fstate_t state_q;

	logic                          op_q;
	logic [dpws_pkg::ADDR_W-1:0]   addr_q;
	logic [dpws_pkg::DATA_W-1:0]   data_q;
	logic [dpws_pkg::LEN_W-1:0]    rlen_q;
	logic                          last_q;
	logic [dpws_pkg::PROD_W-1:0]   prod_q;
	logic [dpws_pkg::PAGE_W-1:0]   pg_q;
	logic [dpws_pkg::OFS_W-1:0]    of_q;

	logic                          in_transfer_q;
	logic                          chunk_open_q;
	logic [dpws_pkg::PAGE_W-1:0]   cur_page_q;
	logic [dpws_pkg::OFS_W-1:0]    cur_ofs_q;
	logic [dpws_pkg::PACK_W-1:0]   chunk_addr_q;

	logic [dpws_pkg::DIV_X_W-1:0]  div_x;
	logic [dpws_pkg::QUOT_W-1:0]   quot;
	logic [dpws_pkg::DIV_X_W-1:0]  rem_w;
	logic [14:0]                   pm_v;
	logic [dpws_pkg::OFS_W-1:0]    split_ofs;

	logic                          accept;
	logic [dpws_pkg::PAGE_W-1:0]   wr_page;
	logic [dpws_pkg::OFS_W-1:0]    wr_ofs;
	logic [dpws_pkg::PACK_W-1:0]   wr_caddr;
	logic [10:0]                   page_size;
	logic                          boundary;
	logic                          needs_push;
	logic                          issue_go;

	assign full   = (state_q != FS_IDLE);
	assign accept = push && !full;

	// Page/offset split: address >> 3 (or >> 4) divided by 33.
	always_comb begin
		if (page_mode) begin
			div_x = dpws_pkg::DIV_X_W'(addr_q[dpws_pkg::ADDR_W-1:4]);
		end else begin
			div_x = addr_q[dpws_pkg::ADDR_W-1:3];
		end
		quot  = prod_q[dpws_pkg::PROD_W-1:dpws_pkg::DIV_SHIFT];
		rem_w = div_x - (dpws_pkg::DIV_X_W'(quot) << 5) - dpws_pkg::DIV_X_W'(quot);
		if (page_mode) begin
			split_ofs = {rem_w[5:0], addr_q[3:0]};
		end else begin
			split_ofs = {1'b0, rem_w[5:0], addr_q[2:0]};
		end
		pm_v = 15'(quot);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (pm_v >= (15'(PAGE_COUNT) << k)) begin
				pm_v = pm_v - (15'(PAGE_COUNT) << k);
			end
		end
	end

	always_comb begin
		page_size = page_mode ? dpws_pkg::PAGE_SIZE_LARGE : dpws_pkg::PAGE_SIZE_SMALL;
		wr_page   = in_transfer_q ? cur_page_q : pg_q;
		wr_ofs    = in_transfer_q ? cur_ofs_q : of_q;
		wr_caddr  = chunk_open_q ? chunk_addr_q : dpws_pkg::pack_addr(wr_page, wr_ofs, page_mode);
		boundary  = (11'(wr_ofs) + 11'd1) >= page_size;

		job = '0;
		job.is_read = op_q;
		job.data    = data_q;
		job.rlen    = rlen_q;
		if (op_q) begin
			job.close      = chunk_open_q;
			job.close_addr = chunk_addr_q;
			job.read_go    = (rlen_q != '0);
			job.op_addr    = dpws_pkg::pack_addr(pg_q, of_q, page_mode);
			needs_push     = chunk_open_q || (rlen_q != '0);
		end else begin
			job.open       = !chunk_open_q;
			job.close      = boundary || last_q;
			job.close_addr = wr_caddr;
			job.op_addr    = wr_caddr;
			needs_push     = 1'b1;
		end
	end

	assign issue_go = (state_q == FS_ISSUE) && (!needs_push || !job_full);
	assign job_push = issue_go && needs_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FS_IDLE;
			in_transfer_q <= 1'b0;
			chunk_open_q  <= 1'b0;
			cur_page_q    <= '0;
			cur_ofs_q     <= '0;
			chunk_addr_q  <= '0;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (accept) begin
						state_q <= FS_MUL;
					end
				end
				FS_MUL:   state_q <= FS_SPLIT;
				FS_SPLIT: state_q <= FS_ISSUE;
				FS_ISSUE: begin
					if (issue_go) begin
						state_q <= FS_IDLE;
						if (op_q) begin
							chunk_open_q  <= 1'b0;
							in_transfer_q <= 1'b0;
						end else begin
							chunk_addr_q  <= wr_caddr;
							chunk_open_q  <= !(boundary || last_q);
							in_transfer_q <= !last_q;
							if (boundary) begin
								cur_ofs_q <= '0;
								if (wr_page == dpws_pkg::PAGE_W'(PAGE_COUNT - 1)) begin
									cur_page_q <= '0;
								end else begin
									cur_page_q <= wr_page + 1'b1;
								end
							end else begin
								cur_ofs_q  <= wr_ofs + 1'b1;
								cur_page_q <= wr_page;
							end
						end
					end
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			addr_q <= start_address;
			data_q <= data_byte;
			rlen_q <= read_length;
			last_q <= transfer_end;
		end
		if (state_q == FS_MUL) begin
			prod_q <= {{dpws_pkg::DIV_X_W{1'b0}}, div_x} *
				{{dpws_pkg::DIV_X_W{1'b0}}, dpws_pkg::RECIP_33};
		end
		if (state_q == FS_SPLIT) begin
			pg_q <= pm_v[dpws_pkg::PAGE_W-1:0];
			of_q <= split_ofs;
		end
	end

endmodule

// ----- hw/rtl/dpws_queue.sv -----
module dpws_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dpws_pkg::job_t wr_job,
	output logic           q_full,
	input  logic           rd_en,
	output dpws_pkg::job_t rd_job,
	output logic           q_valid
);

	localparam int PTR_W = (dpws_pkg::JOB_DEPTH > 1) ? $clog2(dpws_pkg::JOB_DEPTH) : 1;
	localparam int CNT_W = $clog2(dpws_pkg::JOB_DEPTH + 1);

	dpws_pkg::job_t   slot_q [dpws_pkg::JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign q_full  = (count_q == CNT_W'(dpws_pkg::JOB_DEPTH));
	assign q_valid = (count_q != '0);
	assign rd_job  = slot_q[rd_ptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(dpws_pkg::JOB_DEPTH - 1)) begin
			ptr_inc = '0;
		end else begin
			ptr_inc = p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ----- hw/rtl/dpws_back.sv -----
module dpws_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  dpws_pkg::job_t              job,
	output logic                        job_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  action,
	output logic [dpws_pkg::DATA_W-1:0] byte_value,
	output logic [dpws_pkg::LEN_W-1:0]  receive_count,
	output logic                        run_last
);

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_OPEN  = 5'b00010,
		PH_DATA  = 5'b00100,
		PH_CLOSE = 5'b01000,
		PH_READ  = 5'b10000
	} phase_t;

	phase_t                        phase_q;
	phase_t                        start_phase;
	phase_t                        next_phase;
	logic [dpws_pkg::STEP_W-1:0]   step_q;
	dpws_pkg::job_t                job_q;

	logic                          out_valid_q;
	logic [1:0]                    action_q;
	logic [dpws_pkg::DATA_W-1:0]   byte_q;
	logic [dpws_pkg::LEN_W-1:0]    count_q;
	logic                          last_q;

	logic                          advance;
	dpws_pkg::action_t             act;
	logic [dpws_pkg::DATA_W-1:0]   bval;
	logic [dpws_pkg::LEN_W-1:0]    cnt;
	logic                          seg_end;
	logic [dpws_pkg::PACK_W-1:0]   addr;

	assign empty         = !out_valid_q;
	assign action        = action_q;
	assign byte_value    = byte_q;
	assign receive_count = count_q;
	assign run_last      = last_q;

	assign job_pop = (phase_q == PH_IDLE) && job_valid;
	assign advance = (phase_q != PH_IDLE) && (!out_valid_q || pop);

	always_comb begin
		if (job.is_read) begin
			start_phase = job.close ? PH_CLOSE : PH_READ;
		end else begin
			start_phase = job.open ? PH_OPEN : PH_DATA;
		end
	end

	// One action per step; addresses go out most significant byte first.
	always_comb begin
		act     = dpws_pkg::ACT_SEND;
		bval    = '0;
		cnt     = '0;
		seg_end = 1'b0;
		addr    = (phase_q == PH_CLOSE) ? job_q.close_addr : job_q.op_addr;
		unique case (phase_q)
			PH_OPEN: begin
				case (step_q)
					4'd0, 4'd6: act = dpws_pkg::ACT_POLL;
					4'd1:       bval = dpws_pkg::CMD_MEM_TO_BUF;
					4'd2, 4'd8: bval = addr[23:16];
					4'd3, 4'd9: bval = addr[15:8];
					4'd4:       bval = addr[7:0];
					4'd5:       act = dpws_pkg::ACT_DESEL;
					4'd7:       bval = dpws_pkg::CMD_BUF_WRITE;
					4'd10: begin
						bval    = addr[7:0];
						seg_end = 1'b1;
					end
					default: seg_end = 1'b1;
				endcase
			end
			PH_DATA: begin
				bval    = job_q.data;
				seg_end = 1'b1;
			end
			PH_CLOSE: begin
				case (step_q)
					4'd0: act = dpws_pkg::ACT_DESEL;
					4'd1: act = dpws_pkg::ACT_POLL;
					4'd2: bval = dpws_pkg::CMD_PROGRAM;
					4'd3: bval = addr[23:16];
					4'd4: bval = addr[15:8];
					4'd5: bval = addr[7:0];
					default: begin
						act     = dpws_pkg::ACT_DESEL;
						seg_end = 1'b1;
					end
				endcase
			end
			PH_READ: begin
				case (step_q)
					4'd0: act = dpws_pkg::ACT_POLL;
					4'd1: bval = dpws_pkg::CMD_READ;
					4'd2: bval = addr[23:16];
					4'd3: bval = addr[15:8];
					4'd4: bval = addr[7:0];
					4'd5, 4'd6, 4'd7, 4'd8: bval = '0;
					4'd9: begin
						act = dpws_pkg::ACT_RECEIVE;
						cnt = job_q.rlen;
					end
					default: begin
						act     = dpws_pkg::ACT_DESEL;
						seg_end = 1'b1;
					end
				endcase
			end
			default: seg_end = 1'b0;
		endcase
	end

	always_comb begin
		unique case (phase_q)
			PH_OPEN:  next_phase = PH_DATA;
			PH_DATA:  next_phase = job_q.close ? PH_CLOSE : PH_IDLE;
			PH_CLOSE: next_phase = (job_q.is_read && job_q.read_go) ? PH_READ : PH_IDLE;
			default:  next_phase = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				phase_q <= start_phase;
				step_q  <= '0;
			end else if (advance) begin
				if (seg_end) begin
					phase_q <= next_phase;
					step_q  <= '0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (advance) begin
			action_q <= act;
			byte_q   <= bval;
			count_q  <= cnt;
			last_q   <= seg_end && (next_phase == PH_IDLE);
		end
	end

endmodule

// ----- hw/rtl/dataflash_page_write_sequencer.sv -----
// Channel  | Ports                                                  | Beat taken when
// ---------+--------------------------------------------------------+--------------------------
// items    | operation start_address data_byte read_length           | push & !full
//          | transfer_end                                            |
// actions  | action byte_value receive_count run_last                | pop & !empty
// config   | psel penable pwrite paddr pwdata prdata pready          | psel & penable & pwrite
//
// The front takes each item through capture, reciprocal multiply, page split and issue;
// full stays high meanwhile, so no new item is taken until the last one is issued. The
// back loads a job, then emits one action per cycle while pop keeps the output drained
// (a zero-length read with no open chunk never reaches the back).
// Reset clears all transfer state and selects 264-byte pages.
// pop low holds the output register; the back stalls, the 2-entry job queue fills and
// the front waits in its issue cycle with full high.
module dataflash_page_write_sequencer #(
	parameter int PAGE_COUNT = dpws_pkg::PAGE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic                        operation,
	input  logic [dpws_pkg::ADDR_W-1:0] start_address,
	input  logic [dpws_pkg::DATA_W-1:0] data_byte,
	input  logic [dpws_pkg::LEN_W-1:0]  read_length,
	input  logic                        transfer_end,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  action,
	output logic [dpws_pkg::DATA_W-1:0] byte_value,
	output logic [dpws_pkg::LEN_W-1:0]  receive_count,
	output logic                        run_last
);

	localparam logic REG_PAGE_MODE = 1'b0;

	logic           page_mode_q;
	logic           job_push;
	logic           job_full;
	logic           job_valid;
	logic           job_pop;
	dpws_pkg::job_t front_job;
	dpws_pkg::job_t back_job;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PAGE_MODE) ? {31'd0, page_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PAGE_MODE)) begin
			page_mode_q <= pwdata[0];
		end
	end

	dpws_front #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.page_mode     (page_mode_q),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.start_address (start_address),
		.data_byte     (data_byte),
		.read_length   (read_length),
		.transfer_end  (transfer_end),
		.job_push      (job_push),
		.job_full      (job_full),
		.job           (front_job)
	);

	dpws_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (front_job),
		.q_full  (job_full),
		.rd_en   (job_pop),
		.rd_job  (back_job),
		.q_valid (job_valid)
	);

	dpws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job           (back_job),
		.job_pop       (job_pop),
		.empty         (empty),
		.pop           (pop),
		.action        (action),
		.byte_value    (byte_value),
		.receive_count (receive_count),
		.run_last      (run_last)
	);

endmodule
